### rtl/core/fsjr_pkg.sv
package fsjr_pkg;

  localparam int unsigned ENC_W    = 13;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned SET_W    = 15;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned ANGLE_W  = 40;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // unwrap limits of the encoder delta
  localparam logic signed [ENC_W:0] DELTA_LIMIT = 14'sd4095;
  localparam logic signed [ENC_W:0] ENC_SPAN    = 14'sd8191;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_RPM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TICKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_STEP   = 3'd6;

  // 0.8 rad of output in encoder counts
  localparam logic [STEP_W-1:0] SINGLE_STEP_RESET = 20'd75092;

  typedef struct packed {
    logic [ENC_W-1:0]        encoder_now;
    logic [ENC_W-1:0]        encoder_prev;
    logic signed [RPM_W-1:0] motor_rpm;
    logic                    toggle_key;
    logic                    fire_enable;
    logic                    fire_request;
    logic                    burst;
    logic                    remote_off;
  } item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_setpoint;
    logic signed [ANGLE_W-1:0] aim_target;
    logic signed [ANGLE_W-1:0] position;
    logic                      single_mode;
    logic                      reversing;
  } result_t;

endpackage

### rtl/core/fsjr_stream_if.sv
interface fsjr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/feeder_setpoint_with_jam_reverse_top.sv
// Feeder setpoint block with jam reversal and single-shot targeting.
// Channels: "item" takes one control tick (encoder readings, rpm, key and
// fire flags); "result" gives one setpoint record per tick. A transfer is a
// cycle with valid and ready both high. Registers are to be written through
// cfg_we / cfg_index / cfg_data only while the block is idle; the block
// itself does not enforce this; unknown indexes are ignored. A transferred
// tick's result is registered in the result register, or in the skid
// register while that one is held. Throughput: one tick per cycle while
// item ready is high; each update is one pass of short logic.
// A two-deep output stage (result register plus skid register) keeps item
// ready high while one result waits; item ready drops only when both are
// full, and the skid entry drains first once the receiver takes again.
// Reset (rst, synchronous): position, target, speed and stall count clear,
// continuous mode, reversal off, shot armed, registers to their defaults
// (stall and reverse ticks one, single step 75092 counts), output empty.
// POSITION_WIDTH sets the wrap width of position and target (24..64);
// both are reported in 40 bits, sign-extended if narrower, cut if wider.
module feeder_setpoint_with_jam_reverse_top #(
  parameter int unsigned POSITION_WIDTH = 40
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsjr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsjr_pkg::CFG_DATA_W-1:0] cfg_data,
  fsjr_stream_if.sink                     item,
  fsjr_stream_if.source                   result
);
  import fsjr_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;

  // configuration registers
  logic [SET_W-1:0]  base_speed;
  logic [SET_W-1:0]  burst_speed;
  logic [SET_W-1:0]  back_speed;
  logic [SET_W-1:0]  stall_rpm;
  logic [SET_W-1:0]  stall_ticks;
  logic [SET_W-1:0]  reverse_ticks;
  logic [STEP_W-1:0] single_step_counts;

  // tick state
  logic signed [PW-1:0]      position_sum, position_sum_next;
  logic                      fire_mode, fire_mode_next;
  logic [COUNT_W-1:0]        stall_count, stall_count_next;
  logic                      reverse_active, reverse_active_next;
  logic                      armed, armed_next;
  logic signed [SPEED_W-1:0] held_speed, held_speed_next;
  logic signed [PW-1:0]      held_target, held_target_next;

  // output stage
  logic    out_valid, skid_valid;
  result_t out_data, skid_data, res_next;
  logic    accept, out_free;

  item_t                     it;
  logic signed [ENC_W:0]     diff, delta;
  logic [COUNT_W-1:0]        count_inc;
  logic signed [63:0]        pos_ext, target_ext;

  assign it       = item.data;
  assign item.ready = !skid_valid;
  assign accept   = item.valid && !skid_valid;
  assign out_free = !out_valid || result.ready;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed         <= '0;
      burst_speed        <= '0;
      back_speed         <= '0;
      stall_rpm          <= '0;
      stall_ticks        <= SET_W'(1);
      reverse_ticks      <= SET_W'(1);
      single_step_counts <= SINGLE_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_SPEED:    base_speed         <= cfg_data[SET_W-1:0];
        REG_BURST_SPEED:   burst_speed        <= cfg_data[SET_W-1:0];
        REG_BACK_SPEED:    back_speed         <= cfg_data[SET_W-1:0];
        REG_STALL_RPM:     stall_rpm          <= cfg_data[SET_W-1:0];
        REG_STALL_TICKS:   stall_ticks        <= cfg_data[SET_W-1:0];
        REG_REVERSE_TICKS: reverse_ticks      <= cfg_data[SET_W-1:0];
        REG_SINGLE_STEP:   single_step_counts <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // unwrap the encoder delta across the 8191-count span
    diff = $signed({1'b0, it.encoder_now}) - $signed({1'b0, it.encoder_prev});
    if (diff > DELTA_LIMIT) begin
      delta = diff - ENC_SPAN;
    end else if (diff < -DELTA_LIMIT) begin
      delta = diff + ENC_SPAN;
    end else begin
      delta = diff;
    end
    position_sum_next = position_sum + PW'(delta);

    fire_mode_next      = fire_mode ^ it.toggle_key;
    stall_count_next    = stall_count;
    reverse_active_next = reverse_active;
    armed_next          = armed;
    held_speed_next     = held_speed;
    held_target_next    = held_target;
    count_inc           = stall_count + COUNT_W'(1);

    if (!fire_mode_next) begin
      // continuous fire with stall watch and timed reversal
      if (it.fire_enable && it.fire_request) begin
        if (!reverse_active) begin
          held_speed_next = it.burst ? $signed({1'b0, burst_speed})
                                     : $signed({1'b0, base_speed});
          if ($signed({it.motor_rpm[RPM_W-1], it.motor_rpm}) >
              $signed({2'b00, stall_rpm})) begin
            stall_count_next = '0;
          end else if (count_inc >= {1'b0, stall_ticks}) begin
            reverse_active_next = 1'b1;
            stall_count_next    = {1'b0, reverse_ticks};
          end else begin
            stall_count_next = count_inc;
          end
        end else begin
          held_speed_next = -$signed({1'b0, back_speed});
          if (stall_count <= COUNT_W'(1)) begin
            reverse_active_next = 1'b0;
            stall_count_next    = '0;
          end else begin
            stall_count_next = stall_count - COUNT_W'(1);
          end
        end
      end else begin
        held_speed_next = '0;
      end
    end else begin
      // single shot: one step past the negated position per re-armed request
      if (it.fire_enable) begin
        if (it.fire_request) begin
          if (armed) begin
            held_target_next = -position_sum_next - PW'(single_step_counts);
            armed_next       = 1'b0;
          end
        end else begin
          armed_next = 1'b1;
        end
      end else begin
        held_target_next = '0;
      end
      if (it.remote_off) begin
        held_target_next = '0;
      end
    end

    // a dropped request clears speed, target and position
    if (!it.fire_request) begin
      held_speed_next   = '0;
      position_sum_next = '0;
      held_target_next  = '0;
    end

    pos_ext    = 64'(position_sum_next);
    target_ext = 64'(held_target_next);
    res_next.speed_setpoint = held_speed_next;
    res_next.aim_target     = target_ext[ANGLE_W-1:0];
    res_next.position       = pos_ext[ANGLE_W-1:0];
    res_next.single_mode    = fire_mode_next;
    res_next.reversing      = reverse_active_next;
  end

  // state advances on each transfer in
  always_ff @(posedge clk) begin
    if (rst) begin
      position_sum   <= '0;
      fire_mode      <= 1'b0;
      stall_count    <= '0;
      reverse_active <= 1'b0;
      armed          <= 1'b1;
      held_speed     <= '0;
      held_target    <= '0;
    end else if (accept) begin
      position_sum   <= position_sum_next;
      fire_mode      <= fire_mode_next;
      stall_count    <= stall_count_next;
      reverse_active <= reverse_active_next;
      armed          <= armed_next;
      held_speed     <= held_speed_next;
      held_target    <= held_target_next;
    end
  end

  // result register with skid: drain the skid entry first, hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res_next;
      end
    end else if (accept) begin
      skid_data <= res_next;
    end
  end

endmodule

### bench/fsjr_setpoint_checker.sv
module fsjr_setpoint_checker
  import fsjr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item_data,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result_data,
  output int                    fail_count,
  output int                    pending
);

  // register copies
  logic [SET_W-1:0]  base_speed, burst_speed, back_speed, stall_rpm;
  logic [SET_W-1:0]  stall_ticks, reverse_ticks;
  logic [STEP_W-1:0] step_counts;

  // feeder state
  logic [ANGLE_W-1:0] pos_acc;
  logic [ANGLE_W-1:0] shot_target;
  logic               single_shot;
  logic               jam_reverse;
  logic               shot_armed;
  int                 stall_cnt;
  int                 speed_hold;

  result_t setpoints_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  // one control tick of the feeder
  task automatic advance_tick(input item_t t, output result_t r);
    int                 d;
    int                 rpm;
    logic signed [ANGLE_W-1:0] dx;
    d = int'(t.encoder_now) - int'(t.encoder_prev);
    if (d > int'(DELTA_LIMIT)) d -= int'(ENC_SPAN);
    if (d < -int'(DELTA_LIMIT)) d += int'(ENC_SPAN);
    dx = ANGLE_W'(d);
    pos_acc = pos_acc + dx;
    rpm = $signed(t.motor_rpm);

    if (t.toggle_key) single_shot = !single_shot;

    if (!single_shot) begin
      if (!t.fire_enable || !t.fire_request) begin
        speed_hold = 0;
      end else if (!jam_reverse) begin
        if (rpm > int'(stall_rpm)) begin
          stall_cnt = 0;
        end else begin
          stall_cnt++;
          if (stall_cnt >= int'(stall_ticks)) begin
            jam_reverse = 1'b1;
            stall_cnt   = int'(reverse_ticks);
          end
        end
        speed_hold = t.burst ? int'(burst_speed) : int'(base_speed);
      end else begin
        stall_cnt--;
        if (stall_cnt <= 0) begin
          jam_reverse = 1'b0;
          stall_cnt   = 0;
        end
        speed_hold = -int'(back_speed);
      end
    end else begin
      if (t.fire_enable) begin
        if (t.fire_request) begin
          if (shot_armed) begin
            shot_target = ANGLE_W'(0) - pos_acc - ANGLE_W'(step_counts);
            shot_armed  = 1'b0;
          end
        end else begin
          shot_armed = 1'b1;
        end
      end else begin
        shot_target = '0;
      end
      if (t.remote_off) shot_target = '0;
    end

    if (!t.fire_request) begin
      speed_hold  = 0;
      pos_acc     = '0;
      shot_target = '0;
    end

    r.speed_setpoint = speed_hold[SPEED_W-1:0];
    r.aim_target     = shot_target;
    r.position       = pos_acc;
    r.single_mode    = single_shot;
    r.reversing      = jam_reverse;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t next_set;
    if (rst) begin
      base_speed    = '0;
      burst_speed   = '0;
      back_speed    = '0;
      stall_rpm     = '0;
      stall_ticks   = SET_W'(1);
      reverse_ticks = SET_W'(1);
      step_counts   = SINGLE_STEP_RESET;
      pos_acc       = '0;
      shot_target   = '0;
      single_shot   = 1'b0;
      jam_reverse   = 1'b0;
      shot_armed    = 1'b1;
      stall_cnt     = 0;
      speed_hold    = 0;
      setpoints_due.delete();
    end else begin
      // compare before predicting, so a result never meets its own tick
      if (result_valid && result_ready) begin
        if (setpoints_due.size() == 0) begin
          report_mismatch("unexpected result", 64'(result_data.position), '0);
        end else begin
          want = setpoints_due.pop_front();
          if (result_data.speed_setpoint !== want.speed_setpoint)
            report_mismatch("speed_setpoint", 64'(result_data.speed_setpoint),
                            64'(want.speed_setpoint));
          if (result_data.aim_target !== want.aim_target)
            report_mismatch("aim_target", 64'(result_data.aim_target),
                            64'(want.aim_target));
          if (result_data.position !== want.position)
            report_mismatch("position", 64'(result_data.position), 64'(want.position));
          if (result_data.single_mode !== want.single_mode)
            report_mismatch("single_mode", 64'(result_data.single_mode),
                            64'(want.single_mode));
          if (result_data.reversing !== want.reversing)
            report_mismatch("reversing", 64'(result_data.reversing),
                            64'(want.reversing));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_SPEED:    base_speed    = cfg_data[SET_W-1:0];
          REG_BURST_SPEED:   burst_speed   = cfg_data[SET_W-1:0];
          REG_BACK_SPEED:    back_speed    = cfg_data[SET_W-1:0];
          REG_STALL_RPM:     stall_rpm     = cfg_data[SET_W-1:0];
          REG_STALL_TICKS:   stall_ticks   = cfg_data[SET_W-1:0];
          REG_REVERSE_TICKS: reverse_ticks = cfg_data[SET_W-1:0];
          REG_SINGLE_STEP:   step_counts   = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        advance_tick(item_data, next_set);
        setpoints_due.push_back(next_set);
      end
    end
    pending <= setpoints_due.size();
  end

endmodule

### bench/feeder_setpoint_with_jam_reverse_top_tb.sv
module feeder_setpoint_with_jam_reverse_top_tb;
  import fsjr_pkg::*;

  typedef struct {
    logic [SET_W-1:0]  base_speed;
    logic [SET_W-1:0]  burst_speed;
    logic [SET_W-1:0]  back_speed;
    logic [SET_W-1:0]  stall_rpm;
    logic [SET_W-1:0]  stall_ticks;
    logic [SET_W-1:0]  reverse_ticks;
    logic [STEP_W-1:0] step_counts;
  } feeder_settings_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // idling switch and long receiver hold-off request, shared between processes
  bit idle_on;
  bit hold_off;
  int cur_stall_rpm;

  int fail_count;
  int pending;

  fsjr_stream_if #(.T(item_t))   tick_ch ();
  fsjr_stream_if #(.T(result_t)) setpoint_ch ();

  feeder_setpoint_with_jam_reverse_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (tick_ch),
    .result    (setpoint_ch)
  );

  fsjr_setpoint_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (tick_ch.valid),
    .item_ready   (tick_ch.ready),
    .item_data    (tick_ch.data),
    .result_valid (setpoint_ch.valid),
    .result_ready (setpoint_ch.ready),
    .result_data  (setpoint_ch.data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run (every tick waiting out a full
  // gap and a full stall, plus the long hold-off).
  initial begin
    #5000000;
    $display("feeder_setpoint_with_jam_reverse_top_tb: errors");
    $finish;
  end

  function automatic item_t mk_tick(input int now, input int prev, input int rpm,
                                    input bit key, input bit en, input bit req,
                                    input bit bst, input bit poff);
    item_t t;
    t.encoder_now  = ENC_W'(now);
    t.encoder_prev = ENC_W'(prev);
    t.motor_rpm    = RPM_W'(rpm);
    t.toggle_key   = key;
    t.fire_enable  = en;
    t.fire_request = req;
    t.burst        = bst;
    t.remote_off   = poff;
    return t;
  endfunction

  // Mostly well-formed firing: request and enable held high so position builds
  // up and stalls can run to a reversal; keys, drops and power-off are rare.
  function automatic item_t random_tick();
    item_t t;
    t.encoder_prev = ENC_W'($urandom);
    if ($urandom_range(0, 9) < 7)
      t.encoder_now = ENC_W'(int'(t.encoder_prev) + int'($urandom_range(0, 600)) - 300);
    else
      t.encoder_now = ENC_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t.motor_rpm = RPM_W'($urandom_range(0, cur_stall_rpm + 2));
      4:          t.motor_rpm = RPM_W'(-int'($urandom_range(0, 100)));
      default:    t.motor_rpm = RPM_W'($urandom);
    endcase
    t.toggle_key   = ($urandom_range(0, 19) == 0);
    t.fire_enable  = ($urandom_range(0, 9) != 0);
    t.fire_request = ($urandom_range(0, 11) != 0);
    t.burst        = 1'($urandom_range(0, 1));
    t.remote_off   = ($urandom_range(0, 14) == 0);
    return t;
  endfunction

  function automatic feeder_settings_t random_settings();
    feeder_settings_t s;
    s.base_speed    = SET_W'($urandom_range(0, 32767));
    s.burst_speed   = SET_W'($urandom_range(0, 32767));
    s.back_speed    = SET_W'($urandom_range(0, 32767));
    s.stall_rpm     = SET_W'($urandom_range(0, 3000));
    s.stall_ticks   = SET_W'($urandom_range(1, 8));
    s.reverse_ticks = SET_W'($urandom_range(1, 8));
    s.step_counts   = STEP_W'($urandom_range(0, 1048575));
    return s;
  endfunction

  // Offer one tick and hold it until the transfer edge.
  task automatic send_tick(input item_t t);
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // Drop valid and wait for every outstanding setpoint.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Only ever called with the block idle.
  task automatic load_settings(input feeder_settings_t s);
    write_reg(REG_BASE_SPEED,    CFG_DATA_W'(s.base_speed));
    write_reg(REG_BURST_SPEED,   CFG_DATA_W'(s.burst_speed));
    write_reg(REG_BACK_SPEED,    CFG_DATA_W'(s.back_speed));
    write_reg(REG_STALL_RPM,     CFG_DATA_W'(s.stall_rpm));
    write_reg(REG_STALL_TICKS,   CFG_DATA_W'(s.stall_ticks));
    write_reg(REG_REVERSE_TICKS, CFG_DATA_W'(s.reverse_ticks));
    write_reg(REG_SINGLE_STEP,   CFG_DATA_W'(s.step_counts));
    cfg_we <= 1'b0;
    cur_stall_rpm = int'(s.stall_rpm);
  endtask

  task automatic random_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        tick_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      send_tick(random_tick());
    end
  endtask

  task automatic run_phase(input feeder_settings_t s, input int n, input bit idle);
    settle();
    load_settings(s);
    idle_on = idle;
    random_ticks(n);
  endtask

  // Receiver: random bursts of ready and, with idling on, of stall, plus one long
  // hold-off on request so the output stage fills and the block stalls its input.
  initial begin
    setpoint_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        setpoint_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        setpoint_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        setpoint_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    feeder_settings_t s;
    idle_on  = 1'b0;
    hold_off = 1'b0;
    cur_stall_rpm = 0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: stall threshold 50 rpm, three ticks to jam, four ticks reverse.
    s.base_speed    = SET_W'(1000);
    s.burst_speed   = SET_W'(20000);
    s.back_speed    = SET_W'(500);
    s.stall_rpm     = SET_W'(50);
    s.stall_ticks   = SET_W'(3);
    s.reverse_ticks = SET_W'(4);
    s.step_counts   = SINGLE_STEP_RESET;
    load_settings(s);
    send_tick(mk_tick(100,  0,    1000,   0, 1, 1, 0, 0)); // base speed
    send_tick(mk_tick(8191, 0,    1000,   0, 1, 1, 1, 0)); // burst, full-span fold
    send_tick(mk_tick(0,    8191, -32768, 0, 1, 1, 0, 0)); // most negative rpm stalls
    send_tick(mk_tick(4095, 0,    0,      0, 1, 1, 0, 0)); // delta at the limit
    send_tick(mk_tick(4096, 0,    32767,  0, 1, 1, 0, 0)); // fold down, stall clears
    send_tick(mk_tick(0,    4096, 0,      0, 1, 1, 0, 0)); // fold up
    send_tick(mk_tick(0,    4095, 0,      0, 1, 1, 0, 0));
    send_tick(mk_tick(10,   20,   0,      0, 1, 1, 0, 0)); // third stalled tick: jam
    send_tick(mk_tick(30,   20,   0,      0, 1, 1, 0, 0)); // reversing
    send_tick(mk_tick(40,   30,   0,      0, 0, 1, 0, 0)); // enable low keeps the count
    send_tick(mk_tick(50,   40,   0,      0, 1, 0, 0, 0)); // request drop clears
    send_tick(mk_tick(60,   50,   0,      0, 1, 1, 0, 0));
    send_tick(mk_tick(70,   60,   0,      0, 1, 1, 0, 0));
    send_tick(mk_tick(80,   70,   0,      0, 1, 1, 0, 0)); // last reversing tick
    send_tick(mk_tick(500,  70,   0,      1, 1, 1, 0, 0)); // into single shot, fires
    send_tick(mk_tick(900,  500,  0,      0, 1, 1, 0, 0)); // not re-armed
    send_tick(mk_tick(900,  900,  0,      0, 1, 0, 0, 0)); // re-arm
    send_tick(mk_tick(1200, 900,  0,      0, 1, 1, 0, 1)); // fires, power-off clears
    send_tick(mk_tick(1300, 1200, 0,      0, 0, 1, 0, 0)); // enable low clears target
    send_tick(mk_tick(1300, 1300, 5000,   1, 1, 1, 1, 1)); // back to continuous

    // Random with idling, and the long receiver hold-off at the start.
    settle();
    load_settings(random_settings());
    idle_on  = 1'b1;
    hold_off = 1'b1;
    random_ticks(350);

    // Upper extremes, no idling.
    s.base_speed    = SET_W'(32767);
    s.burst_speed   = SET_W'(32767);
    s.back_speed    = SET_W'(32767);
    s.stall_rpm     = SET_W'(32767);
    s.stall_ticks   = SET_W'(32767);
    s.reverse_ticks = SET_W'(32767);
    s.step_counts   = STEP_W'(1048575);
    run_phase(s, 250, 1'b0);

    // Lower extremes.
    s.base_speed    = '0;
    s.burst_speed   = '0;
    s.back_speed    = '0;
    s.stall_rpm     = '0;
    s.stall_ticks   = SET_W'(1);
    s.reverse_ticks = SET_W'(1);
    s.step_counts   = '0;
    run_phase(s, 250, 1'b1);

    // Zero stall and reverse ticks: jam on the first stalled tick, one-tick reversal.
    s = random_settings();
    s.stall_ticks   = '0;
    s.reverse_ticks = '0;
    s.stall_rpm     = SET_W'(100);
    settle();
    load_settings(s);
    send_tick(mk_tick(10, 0,  500, 0, 1, 1, 0, 0));
    send_tick(mk_tick(20, 10, 0,   0, 1, 1, 1, 0));
    send_tick(mk_tick(30, 20, 0,   0, 1, 1, 0, 0));
    send_tick(mk_tick(40, 30, 0,   0, 1, 1, 0, 0));
    idle_on = 1'b1;
    random_ticks(300);

    run_phase(random_settings(), 350, 1'b1);
    // Final stretch runs flat out.
    run_phase(random_settings(), 250, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("feeder_setpoint_with_jam_reverse_top_tb: clean");
    end else begin
      $display("feeder_setpoint_with_jam_reverse_top_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/fsjr_pkg.sv
rtl/core/fsjr_stream_if.sv
rtl/core/feeder_setpoint_with_jam_reverse_top.sv
bench/fsjr_setpoint_checker.sv
bench/feeder_setpoint_with_jam_reverse_top_tb.sv
